@@ hw/rtl/mesi_moesi_snoop_controller_defines.svh @@
// Assertion macros for the snoop controller checkers.
`ifndef MESI_MOESI_SNOOP_CONTROLLER_DEFINES_SVH
`define MESI_MOESI_SNOOP_CONTROLLER_DEFINES_SVH

// Clocked implication, disabled while reset is high.
`define MSC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("snoop controller check failed");

// Condition in one cycle, consequence in the next, disabled while reset is high.
`define MSC_ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("snoop controller check failed");

`endif

@@ hw/rtl/msc_pkg.sv @@
// Shared types, codes and defaults of the snoop controller.
package msc_pkg;

   localparam int DEF_NUM_LINES   = 64;
   localparam int DEF_OFFSET_BITS = 6;

   localparam logic [2:0] OP_PROC_RD  = 3'd0;
   localparam logic [2:0] OP_PROC_WR  = 3'd1;
   localparam logic [2:0] OP_BUS_RD   = 3'd2;
   localparam logic [2:0] OP_BUS_RDX  = 3'd3;
   localparam logic [2:0] OP_BUS_UPGR = 3'd4;

   localparam logic [2:0] LS_I = 3'd0;
   localparam logic [2:0] LS_S = 3'd1;
   localparam logic [2:0] LS_E = 3'd2;
   localparam logic [2:0] LS_M = 3'd3;
   localparam logic [2:0] LS_O = 3'd4;

   localparam logic [1:0] BUS_NONE = 2'd0;
   localparam logic [1:0] BUS_RD   = 2'd1;
   localparam logic [1:0] BUS_RDX  = 2'd2;
   localparam logic [1:0] BUS_UPGR = 2'd3;

   localparam logic [2:0] CSR_PROTOCOL_MODE = 3'd0;
   localparam logic [2:0] CSR_MEM_LATENCY   = 3'd1;
   localparam logic [2:0] CSR_READ_HIT      = 3'd2;
   localparam logic [2:0] CSR_WRITE_HIT     = 3'd3;
   localparam logic [2:0] CSR_FLUSH         = 3'd4;

   localparam logic [15:0] RST_MEM_LATENCY = 16'd100;
   localparam logic [15:0] RST_READ_HIT    = 16'd1;
   localparam logic [15:0] RST_WRITE_HIT   = 16'd1;
   localparam logic [15:0] RST_FLUSH       = 16'd15;

   typedef struct packed {
      logic clear;
      logic start;
      logic step;
      logic commit;
   } msc_cmd_type;

   typedef struct packed {
      logic last;
      logic out_busy;
   } msc_status_type;

endpackage

@@ hw/rtl/msc_controller.sv @@
// Sequencer for clearing, line scan and commit of the snoop controller.
module msc_controller import msc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  msc_status_type status,
   output msc_cmd_type    cmd
);

   localparam logic [2:0] FSM_CLEAR = 3'd0;
   localparam logic [2:0] FSM_IDLE  = 3'd1;
   localparam logic [2:0] FSM_SCAN  = 3'd2;
   localparam logic [2:0] FSM_DRAIN = 3'd3;
   localparam logic [2:0] FSM_EXEC  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         FSM_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.last) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            cmd.step = 1'b1;
            if (status.last) state_in = FSM_DRAIN;
         end
         FSM_DRAIN: state_in = FSM_EXEC;
         FSM_EXEC: begin
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FSM_CLEAR;
      else state_ff <= state_in;
   end

endmodule

@@ hw/rtl/msc_datapath.sv @@
// Line stores, scan registers, protocol rules and result register.
module msc_datapath import msc_pkg::*; #(
   parameter int NUM_LINES   = DEF_NUM_LINES,
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
   input  logic           clock,
   input  logic           reset,
   input  msc_cmd_type    cmd,
   output msc_status_type status,
   input  logic [2:0]     req_opcode,
   input  logic [31:0]    req_address,
   input  logic           req_copies_exist,
   input  logic           csr_write,
   input  logic [2:0]     csr_index,
   input  logic [15:0]    csr_wdata,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_hit,
   output logic [1:0]     rsp_bus_cmd,
   output logic           rsp_flushed,
   output logic           rsp_mem_access,
   output logic           rsp_invalidated,
   output logic           rsp_writeback,
   output logic [2:0]     rsp_line_state,
   output logic [15:0]    rsp_latency_added,
   output logic [47:0]    rsp_total_time
);

   localparam int TAGW = 32 - OFFSET_BITS;
   localparam int IDXW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_LINES - 1);
   localparam logic [47:0] TIME_MAX = '1;

   logic [TAGW-1:0] tag_mem [NUM_LINES];
   logic [2:0]      st_mem  [NUM_LINES];
   logic [31:0]     fo_mem  [NUM_LINES];

   logic            moesi_ff;
   logic [15:0]     mem_lat_ff, rd_hit_ff, wr_hit_ff, flush_ff;
   logic [31:0]     count_ff;
   logic [47:0]     total_ff;

   logic [2:0]      op_ff;
   logic [TAGW-1:0] tag_ff;
   logic            copies_ff;

   logic [IDXW-1:0] rd_idx_ff, q_idx_ff;
   logic            q_vld_ff;
   logic [TAGW-1:0] tag_q_ff;
   logic [2:0]      st_q_ff;
   logic [31:0]     fo_q_ff;

   logic            found_ff, inv_found_ff;
   logic [IDXW-1:0] hit_idx_ff, inv_idx_ff, vic_idx_ff;
   logic [2:0]      hit_st_ff, vic_st_ff;
   logic [31:0]     best_ff;

   logic            rsp_valid_ff;

   logic            hit_c, fl_c, mem_c, inv_c, fill_c, wb_c, op_ok;
   logic [1:0]      bus_c;
   logic [2:0]      nst_c;
   logic [15:0]     lat_c;
   logic [48:0]     sum_c;
   logic [47:0]     total_c;
   logic [IDXW-1:0] fill_idx, tgt_idx, wr_idx;
   logic            st_we, fo_we, tag_we;

   assign status = '{last: (rd_idx_ff == LAST_IDX), out_busy: (rsp_valid_ff && rsp_stall)};
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         moesi_ff <= 1'b0;
         mem_lat_ff <= RST_MEM_LATENCY;
         rd_hit_ff <= RST_READ_HIT;
         wr_hit_ff <= RST_WRITE_HIT;
         flush_ff <= RST_FLUSH;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PROTOCOL_MODE: moesi_ff <= csr_wdata[0];
            CSR_MEM_LATENCY:   mem_lat_ff <= csr_wdata;
            CSR_READ_HIT:      rd_hit_ff <= csr_wdata;
            CSR_WRITE_HIT:     wr_hit_ff <= csr_wdata;
            CSR_FLUSH:         flush_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff <= req_opcode;
         tag_ff <= req_address[31:OFFSET_BITS];
         copies_ff <= req_copies_exist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         q_vld_ff <= 1'b0;
      end else begin
         q_vld_ff <= cmd.step;
         if (cmd.start) rd_idx_ff <= '0;
         else if (cmd.clear || cmd.step) begin
            if (rd_idx_ff == LAST_IDX) rd_idx_ff <= '0;
            else rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         tag_q_ff <= tag_mem[rd_idx_ff];
         st_q_ff <= st_mem[rd_idx_ff];
         fo_q_ff <= fo_mem[rd_idx_ff];
         q_idx_ff <= rd_idx_ff;
      end
   end

   // track first match, first invalid line and oldest stamp, highest index on ties
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         found_ff <= 1'b0;
         inv_found_ff <= 1'b0;
         best_ff <= '1;
      end else if (q_vld_ff) begin
         if (!found_ff && st_q_ff != LS_I && tag_q_ff == tag_ff) begin
            found_ff <= 1'b1;
            hit_idx_ff <= q_idx_ff;
            hit_st_ff <= st_q_ff;
         end
         if (!inv_found_ff && st_q_ff == LS_I) begin
            inv_found_ff <= 1'b1;
            inv_idx_ff <= q_idx_ff;
         end
         if (fo_q_ff <= best_ff) begin
            best_ff <= fo_q_ff;
            vic_idx_ff <= q_idx_ff;
            vic_st_ff <= st_q_ff;
         end
      end
   end

   always_comb begin
      hit_c = found_ff;
      nst_c = found_ff ? hit_st_ff : LS_I;
      bus_c = BUS_NONE;
      fl_c = 1'b0;
      mem_c = 1'b0;
      inv_c = 1'b0;
      fill_c = 1'b0;
      lat_c = '0;
      op_ok = 1'b1;
      case (op_ff)
         OP_PROC_RD: begin
            if (!found_ff) begin
               mem_c = 1'b1;
               lat_c = mem_lat_ff;
               fill_c = 1'b1;
               nst_c = copies_ff ? LS_S : LS_E;
               bus_c = BUS_RD;
            end else lat_c = rd_hit_ff;
         end
         OP_PROC_WR: begin
            if (!found_ff) begin
               mem_c = 1'b1;
               lat_c = moesi_ff ? mem_lat_ff : 16'd0;
               fill_c = 1'b1;
               nst_c = LS_M;
               bus_c = BUS_RDX;
            end else if (hit_st_ff == LS_S || (moesi_ff && hit_st_ff == LS_O)) begin
               lat_c = wr_hit_ff;
               nst_c = LS_M;
               bus_c = BUS_UPGR;
            end else if (hit_st_ff == LS_E || hit_st_ff == LS_M) begin
               lat_c = wr_hit_ff;
               nst_c = LS_M;
            end
         end
         OP_BUS_RD: begin
            if (found_ff) begin
               if (moesi_ff) begin
                  if (hit_st_ff == LS_M || hit_st_ff == LS_O) begin
                     fl_c = 1'b1;
                     lat_c = flush_ff;
                     nst_c = LS_O;
                  end else if (hit_st_ff == LS_E) nst_c = LS_S;
               end else if (hit_st_ff == LS_M || hit_st_ff == LS_E || hit_st_ff == LS_S) begin
                  fl_c = 1'b1;
                  lat_c = flush_ff;
                  mem_c = (hit_st_ff == LS_M);
                  nst_c = LS_S;
               end
            end
         end
         OP_BUS_RDX: begin
            if (found_ff) begin
               if (hit_st_ff == LS_M || (moesi_ff && hit_st_ff == LS_O)) begin
                  fl_c = 1'b1;
                  mem_c = 1'b1;
                  lat_c = flush_ff;
               end
               inv_c = 1'b1;
               nst_c = LS_I;
            end
         end
         OP_BUS_UPGR: begin
            if (found_ff && (hit_st_ff == LS_S || (moesi_ff && hit_st_ff == LS_O))) begin
               inv_c = 1'b1;
               nst_c = LS_I;
            end
         end
         default: begin
            op_ok = 1'b0;
            hit_c = 1'b0;
            nst_c = LS_I;
         end
      endcase
      wb_c = fill_c && !inv_found_ff && (vic_st_ff == LS_M || vic_st_ff == LS_O);
      sum_c = {1'b0, total_ff} + {33'd0, lat_c};
      total_c = sum_c[48] ? TIME_MAX : sum_c[47:0];
   end

   assign fill_idx = inv_found_ff ? inv_idx_ff : vic_idx_ff;
   assign tgt_idx = fill_c ? fill_idx : hit_idx_ff;
   assign wr_idx = cmd.clear ? rd_idx_ff : tgt_idx;
   assign st_we = cmd.clear || (cmd.commit && (found_ff || fill_c) && op_ok);
   assign fo_we = cmd.clear || (cmd.commit && fill_c);
   assign tag_we = cmd.commit && fill_c;

   always_ff @(posedge clock) begin
      if (st_we) st_mem[wr_idx] <= cmd.clear ? LS_I : nst_c;
      if (fo_we) fo_mem[wr_idx] <= cmd.clear ? 32'd0 : count_ff;
      if (tag_we) tag_mem[wr_idx] <= tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else if (cmd.commit && op_ok) begin
         count_ff <= count_ff + 32'd1;
         total_ff <= total_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.commit) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit <= hit_c;
         rsp_bus_cmd <= bus_c;
         rsp_flushed <= fl_c;
         rsp_mem_access <= mem_c;
         rsp_invalidated <= inv_c;
         rsp_writeback <= wb_c;
         rsp_line_state <= nst_c;
         rsp_latency_added <= lat_c;
         rsp_total_time <= op_ok ? total_c : total_ff;
      end
   end

endmodule

@@ hw/rtl/mesi_moesi_snoop_controller.sv @@
// Top level of the MESI/MOESI snoop controller for a fully associative cache.
// Each access walks the line stores one line per cycle to find the match, the first
// invalid line and the oldest fill, then updates the chosen line in one commit cycle:
// the result is registered at the commit, and a new access is taken only after the
// previous one has been committed, as the line stores are scanned through a single read
// port. After reset a clearing pass sets every line invalid before the first access
// is taken; CSR writes are taken at any time and must be made only while no access is
// in flight. The result sits in an output register, so the next access can start while
// a result waits to be taken.
module mesi_moesi_snoop_controller import msc_pkg::*; #(
   parameter int NUM_LINES   = DEF_NUM_LINES,
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_address,
   input  logic        req_copies_exist,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [1:0]  rsp_bus_cmd,
   output logic        rsp_flushed,
   output logic        rsp_mem_access,
   output logic        rsp_invalidated,
   output logic        rsp_writeback,
   output logic [2:0]  rsp_line_state,
   output logic [15:0] rsp_latency_added,
   output logic [47:0] rsp_total_time
);

   msc_cmd_type    cmd;
   msc_status_type status;

   assign csr_ready = 1'b1;

   msc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   msc_datapath #(
      .NUM_LINES   (NUM_LINES),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_address       (req_address),
      .req_copies_exist  (req_copies_exist),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_bus_cmd       (rsp_bus_cmd),
      .rsp_flushed       (rsp_flushed),
      .rsp_mem_access    (rsp_mem_access),
      .rsp_invalidated   (rsp_invalidated),
      .rsp_writeback     (rsp_writeback),
      .rsp_line_state    (rsp_line_state),
      .rsp_latency_added (rsp_latency_added),
      .rsp_total_time    (rsp_total_time)
   );

endmodule

@@ hw/rtl/msc_checker.sv @@
// Port-level checks of the snoop controller and their binding.
`include "mesi_moesi_snoop_controller_defines.svh"

module msc_checker import msc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_hit,
   input logic       rsp_invalidated,
   input logic       rsp_writeback,
   input logic [2:0] rsp_line_state
);

   `MSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `MSC_ASSERT_NEXT(a_busy_after_word, clock, reset, req_valid && !req_stall, req_stall)
   `MSC_ASSERT(a_wb_on_miss, clock, reset, rsp_valid && rsp_writeback |-> !rsp_hit)
   `MSC_ASSERT(a_inv_state, clock, reset,
      rsp_valid && rsp_invalidated |-> rsp_hit && rsp_line_state == LS_I)

endmodule

bind mesi_moesi_snoop_controller msc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit         (rsp_hit),
   .rsp_invalidated (rsp_invalidated),
   .rsp_writeback   (rsp_writeback),
   .rsp_line_state  (rsp_line_state)
);
